FILE: hdl/set_assoc_lru_cache_lookup_top_defines.svh
// -----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top_defines
// assertion macros shared by the cache lookup rtl
// -----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SACL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sacl_pkg.sv
// -----------------------------------------------------------------------------
// sacl_pkg
// types and constants of the set-associative lru cache lookup
// -----------------------------------------------------------------------------
package sacl_pkg;

   localparam int MAX_LINES  = 512;
   localparam int MAX_WAYS   = 8;
   localparam int LINE_IDX_W = $clog2(MAX_LINES);
   localparam int WAY_W      = $clog2(MAX_WAYS);
   localparam int DATA_W     = 32;

   // one memory row holds as many lines as a set can have ways
   localparam int ROW_LINES  = MAX_WAYS;
   localparam int ROW_SEL_W  = $clog2(ROW_LINES);
   localparam int ROWS       = MAX_LINES / ROW_LINES;
   localparam int ROW_W      = $clog2(ROWS);

   localparam int OFFSET_CFG_W = 5;
   localparam int SET_CFG_W    = 4;
   localparam int WAYS_CFG_W   = 4;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [OFFSET_CFG_W-1:0] OFFSET_W_MAX   = 5'd16;
   localparam logic [SET_CFG_W-1:0]    SET_W_MAX      = 4'd9;
   localparam logic [OFFSET_CFG_W-1:0] OFFSET_W_RESET = 5'd6;
   localparam logic [SET_CFG_W-1:0]    SET_W_RESET    = 4'd2;
   localparam logic [WAYS_CFG_W-1:0]   WAYS_RESET     = 4'd4;

   localparam logic [DATA_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] tag;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] hits;
      logic [DATA_W-1:0] misses;
   } line_type;

   localparam int LINE_BITS = $bits(line_type);

   typedef line_type [ROW_LINES-1:0] row_type;

   localparam int ROW_BITS = $bits(row_type);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      CFG_OFFSET_W = 2'd0,
      CFG_SET_W    = 2'd1,
      CFG_WAYS     = 2'd2
   } cfg_idx_type;

endpackage

FILE: hdl/set_assoc_lru_cache_lookup_top.sv
// -----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top
// set-associative cache lookup with least-recently-used replacement
// -----------------------------------------------------------------------------
// Each request transfer carries one 32-bit address. The address is split into
// byte offset, set index and tag by the offset_width and set_index_width
// registers; the ways of the set (ways_in_use, 1 to 8) are compared at once.
// A hit refreshes the line's stamp and bumps its hit counter; a miss fills the
// first invalid way, else the way with the oldest stamp (lowest way on a tie),
// and bumps that line's miss counter. One response transfer per request gives
// hit, the line number (set * ways + way, mod 512) and the line's counters;
// counters hold at all ones and then flag counter_saturated. In the accept
// cycle the two memory rows that cover the set are read; in the next cycle
// the ways are compared, the chosen line is written back and the response
// is registered. The next request is taken only after that lookup cycle is
// done, so the block takes no new address while one is in flight; a
// response stall holds the lookup cycle until the response register frees.
// All line state lives in one 64-row memory of eight lines per row. After
// reset a clearing pass zeroes that memory and no request is taken
// meanwhile (register writes are taken as usual).
// Registers: offset_width at 0x0, set_index_width at 0x4, ways_in_use at 0x8.
// -----------------------------------------------------------------------------
`include "set_assoc_lru_cache_lookup_top_defines.svh"

module set_assoc_lru_cache_lookup_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sacl_pkg::DATA_W-1:0]         req_address,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sacl_pkg::LINE_IDX_W-1:0]     rsp_line_used,
   output logic [sacl_pkg::DATA_W-1:0]         rsp_line_hits,
   output logic [sacl_pkg::DATA_W-1:0]         rsp_line_misses,
   output logic                                rsp_counter_saturated,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int DW  = sacl_pkg::DATA_W;
   localparam int LW  = sacl_pkg::LINE_IDX_W;
   localparam int WW  = sacl_pkg::WAY_W;
   localparam int RL  = sacl_pkg::ROW_LINES;
   localparam int RSW = sacl_pkg::ROW_SEL_W;
   localparam int RW  = sacl_pkg::ROW_W;
   localparam int NW  = sacl_pkg::MAX_WAYS;
   localparam int OCW = sacl_pkg::OFFSET_CFG_W;
   localparam int SCW = sacl_pkg::SET_CFG_W;
   localparam int WCW = sacl_pkg::WAYS_CFG_W;
   // set index times ways needs this many bits before the line wrap
   localparam int MW  = LW + WCW;

   // ---------------------------------------------------------------- registers
   logic [OCW-1:0] offset_w_ff;
   logic [SCW-1:0] set_w_ff;
   logic [WCW-1:0] ways_ff;
   logic           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_w_ff <= sacl_pkg::OFFSET_W_RESET;
         set_w_ff    <= sacl_pkg::SET_W_RESET;
         ways_ff     <= sacl_pkg::WAYS_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            sacl_pkg::CFG_OFFSET_W: offset_w_ff <= csr_pwdata[OCW-1:0];
            sacl_pkg::CFG_SET_W:    set_w_ff    <= csr_pwdata[SCW-1:0];
            sacl_pkg::CFG_WAYS:     ways_ff     <= csr_pwdata[WCW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         sacl_pkg::CFG_OFFSET_W: csr_prdata = 32'(offset_w_ff);
         sacl_pkg::CFG_SET_W:    csr_prdata = 32'(set_w_ff);
         sacl_pkg::CFG_WAYS:     csr_prdata = 32'(ways_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // out-of-range register values saturate
   logic [OCW-1:0] ow_eff;
   logic [SCW-1:0] iw_eff;
   logic [WCW-1:0] ways_eff;

   always_comb begin
      ow_eff = (offset_w_ff > sacl_pkg::OFFSET_W_MAX) ? sacl_pkg::OFFSET_W_MAX : offset_w_ff;
      iw_eff = (set_w_ff > sacl_pkg::SET_W_MAX) ? sacl_pkg::SET_W_MAX : set_w_ff;
      if (ways_ff == '0) begin
         ways_eff = WCW'(1);
      end else if (ways_ff > WCW'(NW)) begin
         ways_eff = WCW'(NW);
      end else begin
         ways_eff = ways_ff;
      end
   end

   // ------------------------------------------------------------ state machine
   sacl_pkg::state_type state_ff, state_in;
   logic [RW-1:0]       clear_cnt_ff;
   logic                req_xfer;
   logic                out_free;
   logic                lookup_done;

   assign req_stall   = (state_ff != sacl_pkg::ST_IDLE);
   assign req_xfer    = req_valid & ~req_stall;
   // the response register is empty or drains in this cycle
   assign out_free    = ~rsp_valid | ~rsp_stall;
   assign lookup_done = (state_ff == sacl_pkg::ST_LOOKUP) & out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            if (clear_cnt_ff == RW'(sacl_pkg::ROWS - 1)) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         sacl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sacl_pkg::ST_LOOKUP;
            end
         end
         sacl_pkg::ST_LOOKUP: begin
            if (out_free) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         default: state_in = sacl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == sacl_pkg::ST_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + RW'(1);
         end
      end
   end

   // ------------------------------------------------------------ address split
   logic [DW-1:0]  addr_shift;
   logic [LW-1:0]  set_mask;
   logic [LW-1:0]  set_idx;
   logic [DW-1:0]  tag;
   logic [MW-1:0]  set_times_ways;
   logic [LW-1:0]  base_line;

   always_comb begin
      addr_shift     = req_address >> ow_eff;
      set_mask       = LW'(((LW+1)'(1) << iw_eff) - (LW+1)'(1));
      set_idx        = addr_shift[LW-1:0] & set_mask;
      tag            = req_address >> (6'(ow_eff) + 6'(iw_eff));
      set_times_ways = MW'(set_idx) * MW'(ways_eff);
      // line numbers wrap modulo the line count
      base_line      = set_times_ways[LW-1:0];
   end

   logic [DW-1:0]  tag_ff;
   logic [LW-1:0]  base_ff;
   logic [WCW-1:0] ways_use_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tag_ff      <= tag;
         base_ff     <= base_line;
         ways_use_ff <= ways_eff;
      end
   end

   // ------------------------------------------------------------------ memory
   // the ways of a set are consecutive lines, so they span at most two rows
   logic [RW-1:0]                  rd_row_a;
   logic [RW-1:0]                  rd_row_b;
   logic                           mem_wr_en;
   logic [RW-1:0]                  mem_wr_addr;
   sacl_pkg::row_type              mem_wr_data;
   logic [sacl_pkg::ROW_BITS-1:0]  rd_data_a;
   logic [sacl_pkg::ROW_BITS-1:0]  rd_data_b;

   assign rd_row_a = base_line[LW-1:RSW];
   assign rd_row_b = rd_row_a + RW'(1);

   sacl_ram #(
      .WIDTH (sacl_pkg::ROW_BITS),
      .DEPTH (sacl_pkg::ROWS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (req_xfer),
      .rd_addr_a (rd_row_a),
      .rd_addr_b (rd_row_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // ------------------------------------------------------------ lookup cycle
   sacl_pkg::row_type  row_a;
   sacl_pkg::row_type  row_b;
   sacl_pkg::line_type win   [2*RL];
   sacl_pkg::line_type way_line [NW];
   logic [NW-1:0]      in_use;
   logic [NW-1:0]      match;
   logic [NW-1:0]      free;
   logic [NW-1:0]      oldest;
   logic [WW-1:0]      hit_way;
   logic [WW-1:0]      free_way;
   logic [WW-1:0]      lru_way;
   logic [WW-1:0]      sel_way;
   logic               any_hit;
   logic [RSW:0]       sel_pos;
   sacl_pkg::line_type old_line;
   sacl_pkg::line_type new_line;
   logic               sat;
   logic [DW-1:0]      clock_next;
   logic [DW-1:0]      access_clock_ff;
   logic [LW-1:0]      line_used;
   logic [RW-1:0]      row_base;

   assign row_a    = sacl_pkg::row_type'(rd_data_a);
   assign row_b    = sacl_pkg::row_type'(rd_data_b);
   assign row_base = base_ff[LW-1:RSW];

   always_comb begin
      logic [RSW:0] pos;
      logic         older_all;

      for (int i = 0; i < RL; i++) begin
         win[i]      = row_a[i];
         win[i + RL] = row_b[i];
      end

      for (int w = 0; w < NW; w++) begin
         pos         = (RSW+1)'(base_ff[RSW-1:0]) + (RSW+1)'(w);
         way_line[w] = win[pos];
         in_use[w]   = (WCW'(w) < ways_use_ff);
         match[w]    = in_use[w] & way_line[w].valid & (way_line[w].tag == tag_ff);
         free[w]     = in_use[w] & ~way_line[w].valid;
      end

      // a way is the victim when strictly older than every lower way and
      // no younger than every higher way
      for (int w = 0; w < NW; w++) begin
         older_all = in_use[w];
         for (int v = 0; v < NW; v++) begin
            if (in_use[v] && (v < w) && !(way_line[w].stamp < way_line[v].stamp)) begin
               older_all = 1'b0;
            end
            if (in_use[v] && (v > w) && (way_line[w].stamp > way_line[v].stamp)) begin
               older_all = 1'b0;
            end
         end
         oldest[w] = older_all;
      end

      // lowest way wins each search
      hit_way  = '0;
      free_way = '0;
      lru_way  = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WW'(w);
         end
         if (free[w]) begin
            free_way = WW'(w);
         end
         if (oldest[w]) begin
            lru_way = WW'(w);
         end
      end
   end

   always_comb begin
      any_hit = |match;
      if (any_hit) begin
         sel_way = hit_way;
      end else if (|free) begin
         sel_way = free_way;
      end else begin
         sel_way = lru_way;
      end

      old_line   = way_line[sel_way];
      new_line   = old_line;
      clock_next = access_clock_ff + DW'(1);
      new_line.stamp = clock_next;
      if (any_hit) begin
         sat = (old_line.hits == sacl_pkg::COUNT_MAX);
         if (!sat) begin
            new_line.hits = old_line.hits + DW'(1);
         end
      end else begin
         new_line.valid = 1'b1;
         new_line.tag   = tag_ff;
         sat = (old_line.misses == sacl_pkg::COUNT_MAX);
         if (!sat) begin
            new_line.misses = old_line.misses + DW'(1);
         end
      end

      sel_pos   = (RSW+1)'(base_ff[RSW-1:0]) + (RSW+1)'(sel_way);
      line_used = base_ff + LW'(sel_way);
   end

   // write port: clearing pass after reset, else the lookup write-back
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clear_cnt_ff;
      mem_wr_data = '0;
      if (state_ff == sacl_pkg::ST_CLEAR) begin
         mem_wr_en = 1'b1;
      end else if (lookup_done) begin
         mem_wr_en = 1'b1;
         if (sel_pos[RSW]) begin
            mem_wr_addr = row_base + RW'(1);
            mem_wr_data = row_b;
         end else begin
            mem_wr_addr = row_base;
            mem_wr_data = row_a;
         end
         mem_wr_data[sel_pos[RSW-1:0]] = new_line;
      end
   end

   // access clock: one step per access, one more on a fill
   always_ff @(posedge clock) begin
      if (reset) begin
         access_clock_ff <= '0;
      end else if (lookup_done) begin
         access_clock_ff <= any_hit ? clock_next : clock_next + DW'(1);
      end
   end

   // -------------------------------------------------------- response register
   logic           rsp_valid_ff;
   logic           rsp_hit_ff;
   logic [LW-1:0]  rsp_line_ff;
   logic [DW-1:0]  rsp_hits_ff;
   logic [DW-1:0]  rsp_misses_ff;
   logic           rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (lookup_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_done) begin
         rsp_hit_ff    <= any_hit;
         rsp_line_ff   <= line_used;
         rsp_hits_ff   <= new_line.hits;
         rsp_misses_ff <= new_line.misses;
         rsp_sat_ff    <= sat;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_line_used         = rsp_line_ff;
   assign rsp_line_hits         = rsp_hits_ff;
   assign rsp_line_misses       = rsp_misses_ff;
   assign rsp_counter_saturated = rsp_sat_ff;

   // -------------------------------------------------------------- assertions
   // an accepted address always moves on to the lookup cycle
   `SACL_ASSERT_NEXT(a_accept_to_lookup, req_xfer, state_ff == sacl_pkg::ST_LOOKUP, "accept did not start a lookup")

   // no address is taken during the clearing pass
   `SACL_ASSERT_NOW(a_clear_stalls, state_ff == sacl_pkg::ST_CLEAR, req_stall, "request taken while clearing")

   // every finished lookup moves the access clock
   `SACL_ASSERT_NEXT(a_clock_moves, lookup_done, access_clock_ff != $past(access_clock_ff), "access clock did not advance")

   // the counter that was bumped can never read zero
   `SACL_ASSERT_NOW(a_miss_nonzero, rsp_valid && !rsp_hit, rsp_line_misses != '0, "miss counter zero after a fill")
   `SACL_ASSERT_NOW(a_hit_nonzero, rsp_valid && rsp_hit, rsp_line_hits != '0, "hit counter zero after a hit")

   // a saturation flag goes with the bumped counter at all ones
   `SACL_ASSERT_NOW(a_sat_at_max, rsp_valid && rsp_counter_saturated, (rsp_hit ? rsp_line_hits : rsp_line_misses) == sacl_pkg::COUNT_MAX, "saturation flagged below maximum")

endmodule

FILE: hdl/sacl_ram.sv
// -----------------------------------------------------------------------------
// sacl_ram
// generic ram, one write port, two read ports with registered read data
// -----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]          rd_data_a,
   output logic [WIDTH-1:0]          rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
